// File: design/grid_raycast_column_macros.svh
// Assertion helpers shared by the ray caster modules.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef GRID_RAYCAST_COLUMN_MACROS_SVH
`define GRID_RAYCAST_COLUMN_MACROS_SVH
`ifndef SYNTHESIS
`define GRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GRC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define GRC_ASSERT(label, prop, msg)
`define GRC_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// File: design/grc_pkg.sv
`default_nettype none
package grc_pkg;

    // Request opcodes.
    localparam logic OPC_CAST  = 1'b0;
    localparam logic OPC_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;

    // Register reset values.
    localparam logic [14:0]        RST_POS_X   = 15'd16384;
    localparam logic [14:0]        RST_POS_Y   = 15'd16384;
    localparam logic signed [15:0] RST_DIR_X   = -16'sd16384;
    localparam logic signed [15:0] RST_DIR_Y   = 16'sd0;
    localparam logic signed [15:0] RST_PLANE_X = 16'sd0;
    localparam logic signed [15:0] RST_PLANE_Y = 16'sd10813;

    // Fixed-point constants.
    localparam int          CAM_OFFSET = 16384;
    localparam int          FRAC_W     = 36;
    localparam logic [15:0] DIST_SAT   = 16'hFFFF;
    localparam logic [11:0] LH_SAT     = 12'd4095;

    // Controller states.
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAM,
        ST_RAY_MUL,
        ST_RAY_ADD,
        ST_ABS,
        ST_INIT_MUL,
        ST_STEP,
        ST_CHECK,
        ST_DIST,
        ST_DIST_WAIT,
        ST_LH,
        ST_LH_WAIT,
        ST_TEX_MUL,
        ST_TEX_FRAC,
        ST_DONE
    } state_t;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_WRITE,
        OP_CAPTURE,
        OP_CAM_SET,
        OP_RAY_MUL,
        OP_RAY_ADD,
        OP_ABS,
        OP_INIT_MUL,
        OP_STEP,
        OP_CHECK,
        OP_DIST_DIV,
        OP_DIST_MAX,
        OP_DIST_SET,
        OP_LH_DIV,
        OP_LH_MAX,
        OP_LH_SET,
        OP_TEX_MUL,
        OP_TEX_FRAC,
        OP_LOAD_OUT
    } dp_op_t;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic div_done;
        logic leave_map;
        logic tile_hit;
        logic den_zero;
        logic dist_zero;
        logic clear_last;
    } dp_status_t;

endpackage
`default_nettype wire

// File: design/grc_if.sv
`default_nettype none
// Request channel: a cast or a tile write.
interface grc_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [9:0] column;
    logic [4:0] tile_x;
    logic [4:0] tile_y;
    logic [3:0] tile_value;

    modport source (output valid, opcode, column, tile_x, tile_y, tile_value, input ready);
    modport sink (input valid, opcode, column, tile_x, tile_y, tile_value, output ready);
endinterface

// Result channel: one wall column per cast.
interface grc_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [3:0]  wall_tile;
    logic        hit_side;
    logic [15:0] wall_distance;
    logic [11:0] slice_height;
    logic [8:0]  row_first;
    logic [8:0]  row_last;
    logic [5:0]  texture_column;

    modport source (output valid, hit, wall_tile, hit_side, wall_distance, slice_height,
                    row_first, row_last, texture_column, input ready);
    modport sink (input valid, hit, wall_tile, hit_side, wall_distance, slice_height,
                  row_first, row_last, texture_column, output ready);
endinterface
`default_nettype wire

// File: design/grc_div.sv
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module grc_div
    import grc_pkg::*;
#(
    parameter int DVD_W = 42,
    parameter int DVS_W = 34
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W:0]   trial;
    logic             ge;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        ge    = trial >= {1'b0, dvs_reg};
    end

    // Iteration counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(DVD_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CW'(1);
            done_reg <= (cnt_reg == CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// File: design/grc_datapath.sv
`default_nettype none
// Ray caster datapath: configuration, tile map, ray setup, DDA walk,
// distance, slice and texture arithmetic, and the result register.
module grc_datapath
    import grc_pkg::*;
#(
    parameter int MAP_SIZE      = 32,
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    parameter int TEX_SIZE      = 64,
    parameter int MAX_STEPS     = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic [9:0]  column,
    input  wire logic [4:0]  tile_x,
    input  wire logic [4:0]  tile_y,
    input  wire logic [3:0]  tile_value,
    input  dp_op_t           op,
    output dp_status_t       status,
    output logic             hit,
    output logic [3:0]       wall_tile,
    output logic             hit_side,
    output logic [15:0]      wall_distance,
    output logic [11:0]      slice_height,
    output logic [8:0]       row_first,
    output logic [8:0]       row_last,
    output logic [5:0]       texture_column
);

    localparam int DEPTH    = MAP_SIZE * MAP_SIZE;
    localparam int AW       = $clog2(DEPTH);
    localparam int CAM_QMAX = (1023 * 32768) / SCREEN_WIDTH;
    localparam int CAM_QW   = $clog2(CAM_QMAX + 1);
    localparam int CAM_W    = ((CAM_QW > 15) ? CAM_QW : 15) + 1;
    // The column times 32768 is below 2^25, so this reciprocal gives the exact quotient.
    localparam int     CAM_SH  = 25 + $clog2(SCREEN_WIDTH);
    localparam longint CAM_RCP = ((longint'(1) << CAM_SH) + longint'(SCREEN_WIDTH) - 1) /
                                 longint'(SCREEN_WIDTH);
    localparam int     RCP_W   = 27;
    localparam int     CP_W    = RCP_W + 10;
    localparam int PR_W     = 16 + CAM_W;
    localparam int RD_W     = ((30 > PR_W) ? 30 : PR_W) + 1;
    localparam int NUM_MAX  = (MAP_SIZE * 1024 > 32767) ? MAP_SIZE * 1024 : 32767;
    localparam int NUM_W    = $clog2(NUM_MAX + 1);
    // The distance dividend is the wider of the two divisions.
    localparam int DVD_W    = NUM_W + 26;
    localparam int DVS_W    = RD_W;
    localparam int TX_W     = $clog2(1024 * (MAX_STEPS + 1) + 1);
    localparam int PQ_W     = TX_W + RD_W;
    localparam int MX_W     = $clog2(((MAP_SIZE > 32) ? MAP_SIZE : 32) + 1) + 1;
    localparam int NS_W     = MX_W + 12;
    localparam int TEX_W    = $clog2(TEX_SIZE + 1);
    localparam int H_W      = (($clog2(SCREEN_HEIGHT + 1) > 12) ?
                               $clog2(SCREEN_HEIGHT + 1) : 12) + 1;
    localparam int HALF_H   = SCREEN_HEIGHT / 2;
    localparam int LH_NUM   = SCREEN_HEIGHT * 256;

    // Configuration registers.
    logic [14:0]        pos_x_reg, pos_y_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= RST_POS_X;
            pos_y_reg   <= RST_POS_Y;
            dir_x_reg   <= RST_DIR_X;
            dir_y_reg   <= RST_DIR_Y;
            plane_x_reg <= RST_PLANE_X;
            plane_y_reg <= RST_PLANE_Y;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POS_X:   pos_x_reg   <= cfg_data[14:0];
                REG_POS_Y:   pos_y_reg   <= cfg_data[14:0];
                REG_DIR_X:   dir_x_reg   <= cfg_data;
                REG_DIR_Y:   dir_y_reg   <= cfg_data;
                REG_PLANE_X: plane_x_reg <= cfg_data;
                REG_PLANE_Y: plane_y_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Clearing pass counter.
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (op == OP_CLEAR)
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
    end

    // Working registers of one cast.
    logic [9:0]              col_reg;
    logic signed [CAM_W-1:0] cam_reg;
    logic signed [PR_W-1:0]  px_reg, py_reg;
    logic signed [RD_W-1:0]  rdx_reg, rdy_reg;
    logic [RD_W-1:0]         ax_reg, ay_reg;
    logic                    negx_reg, negy_reg;
    logic [10:0]             tx0_reg, ty0_reg;
    logic signed [MX_W-1:0]  mx_reg, my_reg;
    logic [PQ_W-1:0]         p_reg, q_reg;
    logic                    side_reg;
    logic                    hit_reg;
    logic [3:0]              tile_reg;
    logic [15:0]             dist_reg;
    logic [11:0]             lh_reg;
    logic [FRAC_W-1:0]       wlo_reg;
    logic [FRAC_W+TEX_W-1:0] tprod_reg;
    logic [3:0]              rd_data_reg;

    // Divider shared by the distance and the slice height.
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic             div_done;
    logic [DVD_W-1:0] div_q;

    grc_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Camera factor quotient: column * 32768 / SCREEN_WIDTH by reciprocal multiplication.
    logic [CP_W-1:0]  cam_prod;
    logic [CAM_W-1:0] cam_q;

    always_comb
    begin
        cam_prod = CP_W'(col_reg) * CP_W'(CAM_RCP);
        cam_q    = CAM_W'(cam_prod >> (CAM_SH - 15));
    end

    // One DDA step: pick the nearer boundary and the cell beyond it.
    logic                   step_x;
    logic signed [MX_W-1:0] mx_nx, my_nx;
    logic                   leave_map;
    logic [AW-1:0]          rd_addr;

    always_comb
    begin
        step_x = p_reg < q_reg;
        mx_nx  = mx_reg;
        my_nx  = my_reg;
        if (step_x)
            mx_nx = negx_reg ? mx_reg - MX_W'(1) : mx_reg + MX_W'(1);
        else
            my_nx = negy_reg ? my_reg - MX_W'(1) : my_reg + MX_W'(1);
        leave_map = mx_nx[MX_W-1] || my_nx[MX_W-1] ||
                    (mx_nx[MX_W-2:0] >= (MX_W-1)'(MAP_SIZE)) ||
                    (my_nx[MX_W-2:0] >= (MX_W-1)'(MAP_SIZE));
        rd_addr = AW'(32'(mx_nx[MX_W-2:0]) * MAP_SIZE + 32'(my_nx[MX_W-2:0]));
    end

    // Distance from the player to the boundary that was crossed.
    logic signed [NS_W-1:0] num;
    logic [NS_W-1:0]        num_abs;
    logic [RD_W-1:0]        den;

    always_comb
    begin
        if (side_reg)
            num = (NS_W'(my_reg) <<< 10) + (negy_reg ? NS_W'(1024) : NS_W'(0)) -
                  $signed({{(NS_W-15){1'b0}}, pos_y_reg});
        else
            num = (NS_W'(mx_reg) <<< 10) + (negx_reg ? NS_W'(1024) : NS_W'(0)) -
                  $signed({{(NS_W-15){1'b0}}, pos_x_reg});
        num_abs = num[NS_W-1] ? NS_W'(-num) : NS_W'(num);
        den     = side_reg ? ay_reg : ax_reg;
    end

    // Divider operand selection.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (op)
            OP_DIST_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = {num_abs[NUM_W-1:0], 26'b0};
                div_divisor  = den;
            end
            OP_LH_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = DVD_W'(LH_NUM);
                div_divisor  = DVS_W'(dist_reg);
            end
            default: ;
        endcase
    end

    // Hit point along the wall, low fraction bits only.
    logic signed [RD_W+16:0] wprod;
    logic [9:0]              pos_lo;

    always_comb
    begin
        wprod  = $signed({1'b0, dist_reg}) * (side_reg ? rdx_reg : rdy_reg);
        pos_lo = side_reg ? pos_x_reg[9:0] : pos_y_reg[9:0];
    end

    // Final slice rows and texture column.
    logic [H_W-1:0]   half_lh, row_start, row_end;
    logic [TEX_W-1:0] tex, tex_m;
    logic             mirror;

    always_comb
    begin
        half_lh   = H_W'(lh_reg >> 1);
        row_start = (half_lh > H_W'(HALF_H)) ? '0 : H_W'(HALF_H) - half_lh;
        row_end   = H_W'(HALF_H) + half_lh;
        if (row_end >= H_W'(SCREEN_HEIGHT))
            row_end = H_W'(SCREEN_HEIGHT - 1);
        tex    = tprod_reg[FRAC_W+TEX_W-1:FRAC_W];
        mirror = side_reg ? negy_reg : (!negx_reg && (ax_reg != '0));
        tex_m  = mirror ? TEX_W'(TEX_SIZE - 1) - tex : tex;
    end

    // Cast sequence registers.
    always_ff @(posedge clk)
    begin
        case (op)
            OP_CAPTURE:
            begin
                col_reg <= column;
                hit_reg <= 1'b0;
            end
            OP_CAM_SET:
            begin
                cam_reg <= $signed(cam_q) - CAM_W'(CAM_OFFSET);
            end
            OP_RAY_MUL:
            begin
                px_reg <= plane_x_reg * cam_reg;
                py_reg <= plane_y_reg * cam_reg;
            end
            OP_RAY_ADD:
            begin
                rdx_reg <= (RD_W'(dir_x_reg) <<< 14) + RD_W'(px_reg);
                rdy_reg <= (RD_W'(dir_y_reg) <<< 14) + RD_W'(py_reg);
            end
            OP_ABS:
            begin
                ax_reg   <= rdx_reg[RD_W-1] ? RD_W'(-rdx_reg) : RD_W'(rdx_reg);
                ay_reg   <= rdy_reg[RD_W-1] ? RD_W'(-rdy_reg) : RD_W'(rdy_reg);
                negx_reg <= rdx_reg[RD_W-1];
                negy_reg <= rdy_reg[RD_W-1];
                tx0_reg  <= rdx_reg[RD_W-1] ? {1'b0, pos_x_reg[9:0]} :
                            11'd1024 - {1'b0, pos_x_reg[9:0]};
                ty0_reg  <= rdy_reg[RD_W-1] ? {1'b0, pos_y_reg[9:0]} :
                            11'd1024 - {1'b0, pos_y_reg[9:0]};
                mx_reg   <= MX_W'(pos_x_reg[14:10]);
                my_reg   <= MX_W'(pos_y_reg[14:10]);
            end
            OP_INIT_MUL:
            begin
                p_reg <= PQ_W'(tx0_reg * ay_reg);
                q_reg <= PQ_W'(ty0_reg * ax_reg);
            end
            OP_STEP:
            begin
                mx_reg   <= mx_nx;
                my_reg   <= my_nx;
                side_reg <= !step_x;
                if (step_x)
                    p_reg <= p_reg + (PQ_W'(ay_reg) << 10);
                else
                    q_reg <= q_reg + (PQ_W'(ax_reg) << 10);
            end
            OP_CHECK:
            begin
                hit_reg  <= 1'b1;
                tile_reg <= rd_data_reg;
            end
            OP_DIST_MAX:
            begin
                dist_reg <= DIST_SAT;
            end
            OP_DIST_SET:
            begin
                dist_reg <= (div_q > DVD_W'(DIST_SAT)) ? DIST_SAT : div_q[15:0];
            end
            OP_LH_MAX:
            begin
                lh_reg <= LH_SAT;
            end
            OP_LH_SET:
            begin
                lh_reg <= (div_q > DVD_W'(LH_SAT)) ? LH_SAT : div_q[11:0];
            end
            OP_TEX_MUL:
            begin
                wlo_reg <= {pos_lo, 26'b0} + FRAC_W'(wprod);
            end
            OP_TEX_FRAC:
            begin
                tprod_reg <= wlo_reg * TEX_W'(TEX_SIZE);
            end
            default: ;
        endcase
    end

    // Result register; a miss reports all fields as zero.
    always_ff @(posedge clk)
    begin
        if (op == OP_LOAD_OUT)
        begin
            hit            <= hit_reg;
            wall_tile      <= hit_reg ? tile_reg : '0;
            hit_side       <= hit_reg ? side_reg : 1'b0;
            wall_distance  <= hit_reg ? dist_reg : '0;
            slice_height   <= hit_reg ? lh_reg : '0;
            row_first      <= hit_reg ? 9'(row_start) : '0;
            row_last       <= hit_reg ? 9'(row_end) : '0;
            texture_column <= hit_reg ? 6'(tex_m) : '0;
        end
    end

    // Tile map: one write port for clearing and tile writes, one read port for the walk.
    logic [3:0]    tile_mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [3:0]    mem_wd;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_cnt_reg;
        mem_wd = '0;
        if (op == OP_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (op == OP_WRITE)
        begin
            mem_we = (32'(tile_x) < MAP_SIZE) && (32'(tile_y) < MAP_SIZE);
            mem_wa = AW'(32'(tile_x) * MAP_SIZE + 32'(tile_y));
            mem_wd = tile_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            tile_mem[mem_wa] <= mem_wd;
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_STEP && !leave_map)
            rd_data_reg <= tile_mem[rd_addr];
    end

    // Status back to the controller.
    always_comb
    begin
        status.div_done   = div_done;
        status.leave_map  = leave_map;
        status.tile_hit   = rd_data_reg != '0;
        status.den_zero   = den == '0;
        status.dist_zero  = dist_reg == '0;
        status.clear_last = clr_cnt_reg == AW'(DEPTH - 1);
    end

endmodule
`default_nettype wire

// File: design/grc_ctrl.sv
`default_nettype none
`include "grid_raycast_column_macros.svh"
// Ray caster controller: sequences the clearing pass, tile writes and casts.
module grc_ctrl
    import grc_pkg::*;
#(
    parameter int MAX_STEPS = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_opcode,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  dp_status_t      status,
    output dp_op_t          op
);

    localparam int SC_W = $clog2(MAX_STEPS + 1);

    state_t          state_reg, state_next;
    logic [SC_W-1:0] step_cnt_reg, step_cnt_next;
    logic            out_valid_reg, out_valid_next;

    // State, step count and result valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath operation.
    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        op             = OP_IDLE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                op = OP_CLEAR;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_opcode == OPC_WRITE)
                    begin
                        op = OP_WRITE;
                    end
                    else
                    begin
                        op            = OP_CAPTURE;
                        step_cnt_next = '0;
                        state_next    = ST_CAM;
                    end
                end
            end
            ST_CAM:
            begin
                op         = OP_CAM_SET;
                state_next = ST_RAY_MUL;
            end
            ST_RAY_MUL:
            begin
                op         = OP_RAY_MUL;
                state_next = ST_RAY_ADD;
            end
            ST_RAY_ADD:
            begin
                op         = OP_RAY_ADD;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                op         = OP_ABS;
                state_next = ST_INIT_MUL;
            end
            ST_INIT_MUL:
            begin
                op         = OP_INIT_MUL;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                op            = OP_STEP;
                step_cnt_next = step_cnt_reg + SC_W'(1);
                state_next    = status.leave_map ? ST_DONE : ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.tile_hit)
                begin
                    op         = OP_CHECK;
                    state_next = ST_DIST;
                end
                else if (step_cnt_reg == SC_W'(MAX_STEPS))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_DIST:
            begin
                if (status.den_zero)
                begin
                    op         = OP_DIST_MAX;
                    state_next = ST_LH;
                end
                else
                begin
                    op         = OP_DIST_DIV;
                    state_next = ST_DIST_WAIT;
                end
            end
            ST_DIST_WAIT:
            begin
                if (status.div_done)
                begin
                    op         = OP_DIST_SET;
                    state_next = ST_LH;
                end
            end
            ST_LH:
            begin
                if (status.dist_zero)
                begin
                    op         = OP_LH_MAX;
                    state_next = ST_TEX_MUL;
                end
                else
                begin
                    op         = OP_LH_DIV;
                    state_next = ST_LH_WAIT;
                end
            end
            ST_LH_WAIT:
            begin
                if (status.div_done)
                begin
                    op         = OP_LH_SET;
                    state_next = ST_TEX_MUL;
                end
            end
            ST_TEX_MUL:
            begin
                op         = OP_TEX_MUL;
                state_next = ST_TEX_FRAC;
            end
            ST_TEX_FRAC:
            begin
                op         = OP_TEX_FRAC;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Wait until the result register is free or being emptied.
                if (!out_valid_reg || out_ready)
                begin
                    op             = OP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    `GRC_ASSERT(a_load_slot_free, (op == OP_LOAD_OUT) |-> (!out_valid_reg || out_ready), "result overwritten while held")
    `GRC_ASSERT(a_step_bound, step_cnt_reg <= SC_W'(MAX_STEPS), "step count beyond limit")
    `GRC_ASSERT_NEXT(a_cast_starts, in_valid && in_ready && (in_opcode == OPC_CAST), state_reg == ST_CAM, "cast did not start")
    `GRC_ASSERT(a_div_done_wait, status.div_done |-> (state_reg == ST_DIST_WAIT || state_reg == ST_LH_WAIT), "divider finished outside a wait state")

endmodule
`default_nettype wire

// File: design/grid_raycast_column.sv
`default_nettype none
// Channel   Dir  Payload
// item      in   opcode, column, tile_x, tile_y, tile_value
// result    out  hit, wall_tile, hit_side, wall_distance, slice_height,
//                row_first, row_last, texture_column
//
// A tile write gives no result.
// A hit goes from the accepting edge through the ray setup states, the walk, the distance
// and slice height divisions and the texture states to the edge that loads the result.
// NUM_W + 26 is the width of the shared one-bit-per-cycle divider used for the distance
// and the slice height, and each walked cell passes through a step state and a check state.
// A miss skips both divisions; a zero ray component skips the distance division.
// After reset a clearing pass writes MAP_SIZE * MAP_SIZE tiles, one per cycle, before the
// first request is taken; configuration writes are taken throughout.
// A finished result waits in the result register; the next request is taken meanwhile,
// and a cast that finishes while that result is still held waits for it to leave.
module grid_raycast_column
    import grc_pkg::*;
#(
    parameter int MAP_SIZE      = 32,
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    parameter int TEX_SIZE      = 64,
    parameter int MAX_STEPS     = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    grc_in_if.sink           item,
    grc_out_if.source        result,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    dp_op_t     op;
    dp_status_t status;

    // Controller.
    grc_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_opcode (item.opcode),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .op        (op)
    );

    // Datapath.
    grc_datapath #(
        .MAP_SIZE      (MAP_SIZE),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .TEX_SIZE      (TEX_SIZE),
        .MAX_STEPS     (MAX_STEPS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .column         (item.column),
        .tile_x         (item.tile_x),
        .tile_y         (item.tile_y),
        .tile_value     (item.tile_value),
        .op             (op),
        .status         (status),
        .hit            (result.hit),
        .wall_tile      (result.wall_tile),
        .hit_side       (result.hit_side),
        .wall_distance  (result.wall_distance),
        .slice_height   (result.slice_height),
        .row_first      (result.row_first),
        .row_last       (result.row_last),
        .texture_column (result.texture_column)
    );

endmodule
`default_nettype wire

// File: tb/grid_raycast_column_test.sv
`timescale 1ns / 1ps
`default_nettype none
module grid_raycast_column_test
    import grc_pkg::*;
();

    typedef struct {
        bit       opcode;
        bit [9:0] column;
        bit [4:0] tile_x;
        bit [4:0] tile_y;
        bit [3:0] tile_value;
    } request_t;

    typedef struct {
        bit        hit;
        bit [3:0]  wall_tile;
        bit        hit_side;
        bit [15:0] wall_distance;
        bit [11:0] slice_height;
        bit [8:0]  row_first;
        bit [8:0]  row_last;
        bit [5:0]  texture_column;
    } wall_slice_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    grc_in_if  item_ch ();
    grc_out_if result_ch ();

    grid_raycast_column u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the map and the camera registers.
    bit [3:0]    tiles [0:31][0:31];
    int          pos_x, pos_y, dir_x, dir_y, plane_x, plane_y;

    request_t    pending_q[$];
    wall_slice_t slice_q[$];
    request_t    cur_req;
    int          burst_left;
    int          gap_left;
    int          fail_count;
    int          stall_mode;
    int          stall_cnt;

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Walk the grid for one screen column and build the expected wall slice.
    function automatic wall_slice_t cast_column(bit [9:0] column);
        wall_slice_t s;
        longint cam, rdx, rdy, ax, ay, mx, my, sx, sy, bx, by;
        longint num, den, wdist, lh, ds, de, wpos, frac, tex;
        bit     found;
        bit     side;
        bit [3:0] tile;
        s = '{default: 0};
        found = 0;
        side = 0;
        tile = 0;
        cam = (longint'(column) * 32768) / 640 - 16384;
        rdx = longint'(dir_x) * 16384 + longint'(plane_x) * cam;
        rdy = longint'(dir_y) * 16384 + longint'(plane_y) * cam;
        ax = magnitude(rdx);
        ay = magnitude(rdy);
        mx = pos_x >> 10;
        my = pos_y >> 10;
        sx = rdx < 0 ? -1 : 1;
        sy = rdy < 0 ? -1 : 1;
        bx = rdx < 0 ? (pos_x & 1023) : 1024 - (pos_x & 1023);
        by = rdy < 0 ? (pos_y & 1023) : 1024 - (pos_y & 1023);
        for (int n = 0; n < 64; n++)
        begin
            // A tie steps across the y boundary.
            if (bx * ay < by * ax)
            begin
                bx += 1024;
                mx += sx;
                side = 0;
            end
            else
            begin
                by += 1024;
                my += sy;
                side = 1;
            end
            if (mx < 0 || mx >= 32 || my < 0 || my >= 32)
                break;
            tile = tiles[mx][my];
            if (tile != 0)
            begin
                found = 1;
                break;
            end
        end
        if (!found)
            return s;

        if (side == 0)
        begin
            num = mx * 1024 + (sx < 0 ? 1024 : 0) - pos_x;
            den = ax;
        end
        else
        begin
            num = my * 1024 + (sy < 0 ? 1024 : 0) - pos_y;
            den = ay;
        end
        if (den == 0)
            wdist = 65535;
        else
        begin
            wdist = (magnitude(num) * (longint'(1) << 26)) / den;
            if (wdist > 65535)
                wdist = 65535;
        end
        lh = (wdist == 0) ? 4095 : (480 * 256) / wdist;
        if (lh > 4095)
            lh = 4095;
        ds = 240 - lh / 2;
        if (ds < 0)
            ds = 0;
        de = lh / 2 + 240;
        if (de >= 480)
            de = 479;
        wpos = (side == 0) ? longint'(pos_y) * (longint'(1) << 26) + wdist * rdy
                           : longint'(pos_x) * (longint'(1) << 26) + wdist * rdx;
        frac = wpos & ((longint'(1) << 36) - 1);
        tex = (frac * 64) >>> 36;
        if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0))
            tex = 64 - tex - 1;

        s.hit = 1;
        s.wall_tile = tile;
        s.hit_side = side;
        s.wall_distance = wdist[15:0];
        s.slice_height = lh[11:0];
        s.row_first = ds[8:0];
        s.row_last = de[8:0];
        s.texture_column = tex[5:0];
        return s;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Clock and reset.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_POS_X;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.opcode = OPC_CAST;
        item_ch.column = '0;
        item_ch.tile_x = '0;
        item_ch.tile_y = '0;
        item_ch.tile_value = '0;
        result_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Request driver: bursts of random length with random gaps.
    always @(posedge clk)
    begin
        logic next_valid;
        if (rst_n)
        begin
            next_valid = item_ch.valid;
            if (!item_ch.valid || item_ch.ready)
            begin
                if (item_ch.valid)
                begin
                    if (cur_req.opcode == OPC_WRITE)
                        tiles[cur_req.tile_x][cur_req.tile_y] = cur_req.tile_value;
                    else
                        slice_q = {slice_q, cast_column(cur_req.column)};
                end
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() > 0)
                begin
                    cur_req = pending_q.pop_front();
                    item_ch.opcode <= cur_req.opcode;
                    item_ch.column <= cur_req.column;
                    item_ch.tile_x <= cur_req.tile_x;
                    item_ch.tile_y <= cur_req.tile_y;
                    item_ch.tile_value <= cur_req.tile_value;
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            item_ch.valid <= next_valid;
        end
    end

    // Result monitor with its own stall pattern.
    always @(posedge clk)
    begin
        wall_slice_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (slice_q.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = slice_q.pop_front();
                    if (result_ch.hit !== want.hit)
                        report_mismatch("hit", result_ch.hit, want.hit);
                    if (result_ch.wall_tile !== want.wall_tile)
                        report_mismatch("wall_tile", result_ch.wall_tile, want.wall_tile);
                    if (result_ch.hit_side !== want.hit_side)
                        report_mismatch("hit_side", result_ch.hit_side, want.hit_side);
                    if (result_ch.wall_distance !== want.wall_distance)
                        report_mismatch("wall_distance", result_ch.wall_distance,
                                        want.wall_distance);
                    if (result_ch.slice_height !== want.slice_height)
                        report_mismatch("slice_height", result_ch.slice_height,
                                        want.slice_height);
                    if (result_ch.row_first !== want.row_first)
                        report_mismatch("row_first", result_ch.row_first, want.row_first);
                    if (result_ch.row_last !== want.row_last)
                        report_mismatch("row_last", result_ch.row_last, want.row_last);
                    if (result_ch.texture_column !== want.texture_column)
                        report_mismatch("texture_column", result_ch.texture_column,
                                        want.texture_column);
                end
            end
            stall_cnt++;
            if (stall_cnt % 512 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= (stall_cnt % 8) != 0;
                2: result_ch.ready <= (stall_cnt % 64) > 40;
                default: result_ch.ready <= $urandom_range(0, 1);
            endcase
        end
    end

    task automatic add_write(int x, int y, int v);
        request_t r;
        r.opcode = OPC_WRITE;
        r.column = $urandom_range(0, 1023);
        r.tile_x = x;
        r.tile_y = y;
        r.tile_value = v;
        pending_q = {pending_q, r};
    endtask

    task automatic add_cast(int column);
        request_t r;
        r.opcode = OPC_CAST;
        r.column = column;
        r.tile_x = $urandom_range(0, 31);
        r.tile_y = $urandom_range(0, 31);
        r.tile_value = $urandom_range(0, 15);
        pending_q = {pending_q, r};
    endtask

    // Hold off until every request has gone and every result has come back.
    task automatic drain_all();
        while (pending_q.size() > 0 || item_ch.valid || slice_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_camera(int px, int py, int dx, int dy, int cx, int cy);
        int vals [6];
        vals = '{px, py, dx, dy, cx, cy};
        for (int i = 0; i < 6; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= vals[i][15:0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        pos_x = px & 32'h7FFF;
        pos_y = py & 32'h7FFF;
        dir_x = int'(signed'(vals[2][15:0]));
        dir_y = int'(signed'(vals[3][15:0]));
        plane_x = int'(signed'(vals[4][15:0]));
        plane_y = int'(signed'(vals[5][15:0]));
    endtask

    // Stimulus.
    initial
    begin
        fail_count = 0;
        burst_left = 4;
        gap_left = 0;
        stall_mode = 0;
        stall_cnt = 0;
        for (int x = 0; x < 32; x++)
            for (int y = 0; y < 32; y++)
                tiles[x][y] = 0;
        pos_x = RST_POS_X;
        pos_y = RST_POS_Y;
        dir_x = RST_DIR_X;
        dir_y = RST_DIR_Y;
        plane_x = RST_PLANE_X;
        plane_y = RST_PLANE_Y;
        @(posedge rst_n);

        // Reset camera: a wall straight ahead, far corners, and a zero y ray at the center.
        add_write(8, 16, 15);
        add_write(31, 31, 9);
        add_write(0, 0, 1);
        add_write(5, 5, 0);
        add_cast(320);
        add_cast(0);
        add_cast(639);
        add_cast(640);
        add_cast(1023);
        add_cast(100);
        drain_all();

        // Player on a cell boundary facing a wall: zero distance.
        write_camera(16384, 16896, -16384, 0, 0, 10813);
        add_write(15, 16, 3);
        add_cast(320);
        add_cast(0);
        add_cast(639);
        add_write(15, 16, 0);
        add_cast(320);
        drain_all();

        // Random phases; the first two use the register extremes.
        for (int p = 0; p < 10; p++)
        begin
            if (p == 0)
                write_camera(0, 0, -32768, -32768, -32768, -32768);
            else if (p == 1)
                write_camera(32767, 32767, 32767, 32767, 32767, 32767);
            else
                write_camera($urandom_range(0, 32767), $urandom_range(0, 32767),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535));
            for (int i = 0; i < 160; i++)
            begin
                if ($urandom_range(0, 9) < 3)
                    add_write($urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 15));
                else if ($urandom_range(0, 9) == 0)
                    add_cast($urandom_range(0, 1023));
                else
                    add_cast($urandom_range(0, 639));
            end
            drain_all();
        end

        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #100_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
